/* rtl/core/qaar_pkg.sv */
// ---------------------------------------------------------------------------
// qaar_pkg
// Constants and helpers for the quaternion axis-angle rotate unit: stage
// numbering, CORDIC angle table and saturation helpers.
// ---------------------------------------------------------------------------
package qaar_pkg;

	// pipeline stage numbering (stage n is the n-th register after the inputs)
	localparam int ST_IN     = 1;
	localparam int ST_SQ     = 2;
	localparam int ST_SUM    = 3;
	localparam int CORDIC_N  = 16;
	localparam int ST_SC     = ST_SUM + CORDIC_N;
	localparam int SQRT_N    = 23;
	localparam int ST_ROOT   = ST_SUM + SQRT_N;
	localparam int ST_NUM    = ST_ROOT + 1;
	localparam int DIV_N     = 15;
	localparam int ST_QUO    = ST_NUM + DIV_N;
	localparam int ST_R      = ST_QUO + 1;
	localparam int ST_P      = ST_R + 1;
	localparam int ST_OUT    = ST_P + 1;
	localparam int LATENCY   = ST_OUT;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

	localparam logic signed [34:0] ATAN_TAB [CORDIC_N] = '{
		35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
		35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
		35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
		35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768
	};

	// clamp to [-16384, 16384]
	function automatic logic signed [15:0] sat_unit(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sd16384) begin
			r = 16'sd16384;
		end else if (v < -34'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// clamp to the 16-bit signed range
	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/quaternion_axis_angle_rotate_unit.sv */
// ---------------------------------------------------------------------------
// quaternion_axis_angle_rotate_unit
// Rotates a Q1.14 quaternion by an axis-angle rotation: axis normalization,
// half-angle CORDIC, rotation quaternion and Hamilton product, all pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   A beat is taken at each rising edge with start high and busy low. busy is
//   always low: the pipeline takes one beat every cycle with no gaps.
//   Each beat carries the quaternion (in_x..in_w), the axis (axis_x..axis_z)
//   and the angle in Q3.12 radians.
//   The result shows on out_x..out_w and ok for exactly one cycle, marked by
//   done. The path runs through the 23-step square root and then the 15-step
//   divider; the 16-step CORDIC runs beside the square root. Results leave in
//   the order beats came in.
//   A zero axis gives ok low and an all-zero quaternion.
//   Throughput is one beat per cycle.
//   The receiver cannot stall: done is a one-cycle strobe and the result is shown
//   for that cycle only.
//   Reset (arst_n low) clears every valid bit at once; beats in flight are
//   dropped and no done follows for them.
// ---------------------------------------------------------------------------
module quaternion_axis_angle_rotate_unit
	import qaar_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] in_x,
	input  logic signed [15:0] in_y,
	input  logic signed [15:0] in_z,
	input  logic signed [15:0] in_w,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] angle,
	output logic               done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic signed [15:0] out_w,
	output logic               ok
);

	logic [ST_OUT:1]   v_s;
	logic [ST_P:1]     ok_s;
	logic [3:0][15:0]  qv_s [ST_IN:ST_R];
	logic [2:0][15:0]  ax_s [ST_IN:ST_QUO];
	logic signed [15:0] ang_s1;

	assign busy = 1'b0;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[ST_OUT-1:1], start};
		end
	end

	always_ff @(posedge clk) begin
		qv_s[ST_IN] <= {in_w, in_z, in_y, in_x};
		ax_s[ST_IN] <= {axis_z, axis_y, axis_x};
		ang_s1      <= angle;
		ok_s[ST_IN] <= (axis_x != 16'sd0) || (axis_y != 16'sd0) || (axis_z != 16'sd0);
	end

	// side lines
	for (genvar st = ST_IN + 1; st <= ST_P; st++) begin : g_ok
		always_ff @(posedge clk) begin
			ok_s[st] <= ok_s[st-1];
		end
	end
	for (genvar st = ST_IN + 1; st <= ST_R; st++) begin : g_q
		always_ff @(posedge clk) begin
			qv_s[st] <= qv_s[st-1];
		end
	end
	for (genvar st = ST_IN + 1; st <= ST_QUO; st++) begin : g_ax
		always_ff @(posedge clk) begin
			ax_s[st] <= ax_s[st-1];
		end
	end

	// ---------------- squares and half-angle range reduction
	logic [31:0]        sq_s2 [3];
	logic signed [33:0] cx_s [ST_SQ:ST_SC-1];
	logic signed [33:0] cy_s [ST_SQ:ST_SC-1];
	logic signed [34:0] cz_s [ST_SQ:ST_SC-1];
	logic               cneg_s [ST_SQ:ST_SC-1];
	logic signed [34:0] h_raw;

	assign h_raw = {{2{ang_s1[15]}}, ang_s1, 17'b0};

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sq_s2[c] <= 32'($signed(ax_s[ST_IN][c]) * $signed(ax_s[ST_IN][c]));
		end
		cx_s[ST_SQ] <= CORDIC_GAIN;
		cy_s[ST_SQ] <= '0;
		if (h_raw > HALF_PI_Q30) begin
			cz_s[ST_SQ]   <= h_raw - PI_Q30;
			cneg_s[ST_SQ] <= 1'b1;
		end else if (h_raw < -HALF_PI_Q30) begin
			cz_s[ST_SQ]   <= h_raw + PI_Q30;
			cneg_s[ST_SQ] <= 1'b1;
		end else begin
			cz_s[ST_SQ]   <= h_raw;
			cneg_s[ST_SQ] <= 1'b0;
		end
	end

	// ---------------- CORDIC, one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			cneg_s[ST_SQ+i+1] <= cneg_s[ST_SQ+i];
			if (!cz_s[ST_SQ+i][34]) begin
				cx_s[ST_SQ+i+1] <= cx_s[ST_SQ+i] - (cy_s[ST_SQ+i] >>> i);
				cy_s[ST_SQ+i+1] <= cy_s[ST_SQ+i] + (cx_s[ST_SQ+i] >>> i);
				cz_s[ST_SQ+i+1] <= cz_s[ST_SQ+i] - ATAN_TAB[i];
			end else begin
				cx_s[ST_SQ+i+1] <= cx_s[ST_SQ+i] + (cy_s[ST_SQ+i] >>> i);
				cy_s[ST_SQ+i+1] <= cy_s[ST_SQ+i] - (cx_s[ST_SQ+i] >>> i);
				cz_s[ST_SQ+i+1] <= cz_s[ST_SQ+i] + ATAN_TAB[i];
			end
		end
	end

	// sine and cosine to Q1.14, then delayed to meet the unit axis
	logic signed [33:0] xf, yf, xr, yr;
	logic signed [15:0] sn_s [ST_SC:ST_QUO];
	logic signed [15:0] cs_s [ST_SC:ST_QUO];

	always_comb begin
		xf = cneg_s[ST_SC-1] ? -cx_s[ST_SC-1] : cx_s[ST_SC-1];
		yf = cneg_s[ST_SC-1] ? -cy_s[ST_SC-1] : cy_s[ST_SC-1];
		xr = (xf + 34'sd32768) >>> 16;
		yr = (yf + 34'sd32768) >>> 16;
	end

	always_ff @(posedge clk) begin
		cs_s[ST_SC] <= sat_unit(xr);
		sn_s[ST_SC] <= sat_unit(yr);
	end
	for (genvar st = ST_SC + 1; st <= ST_QUO; st++) begin : g_sc
		always_ff @(posedge clk) begin
			cs_s[st] <= cs_s[st-1];
			sn_s[st] <= sn_s[st-1];
		end
	end

	// ---------------- axis length: floor(sqrt(S * 2^14)), two radicand bits per stage
	logic [31:0] sum_s [ST_SUM:ST_ROOT-1];
	logic [24:0] rem_s [ST_SUM:ST_ROOT];
	logic [22:0] root_s [ST_SUM:ST_ROOT];

	always_ff @(posedge clk) begin
		sum_s[ST_SUM]  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		rem_s[ST_SUM]  <= '0;
		root_s[ST_SUM] <= '0;
	end
	for (genvar st = ST_SUM + 1; st < ST_ROOT; st++) begin : g_sum
		always_ff @(posedge clk) begin
			sum_s[st] <= sum_s[st-1];
		end
	end

	for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
		localparam int HI = 45 - 2 * k;
		logic [45:0] rad;
		logic [1:0]  pair;
		logic [27:0] d;
		assign rad  = {sum_s[ST_SUM+k], 14'b0};
		assign pair = rad[HI -: 2];
		assign d    = {1'b0, rem_s[ST_SUM+k], pair} - {3'b0, root_s[ST_SUM+k], 2'b01};
		always_ff @(posedge clk) begin
			if (!d[27]) begin
				rem_s[ST_SUM+k+1]  <= d[24:0];
				root_s[ST_SUM+k+1] <= {root_s[ST_SUM+k][21:0], 1'b1};
			end else begin
				rem_s[ST_SUM+k+1]  <= {rem_s[ST_SUM+k][22:0], pair};
				root_s[ST_SUM+k+1] <= {root_s[ST_SUM+k][21:0], 1'b0};
			end
		end
	end

	// ---------------- unit axis: (|a| * 2^21 + L/2) / L, one quotient bit per stage
	logic [22:0] dl_s  [ST_NUM:ST_QUO-1];
	logic [36:0] drem_s [3][ST_NUM:ST_QUO];
	logic [14:0] quo_s  [3][ST_NUM:ST_QUO];

	always_ff @(posedge clk) begin
		dl_s[ST_NUM] <= root_s[ST_ROOT];
		for (int c = 0; c < 3; c++) begin
			drem_s[c][ST_NUM] <= {(ax_s[ST_ROOT][c][15] ? -ax_s[ST_ROOT][c] : ax_s[ST_ROOT][c]),
				21'b0} + 37'(root_s[ST_ROOT] >> 1);
			quo_s[c][ST_NUM] <= '0;
		end
	end
	for (genvar st = ST_NUM + 1; st < ST_QUO; st++) begin : g_dl
		always_ff @(posedge clk) begin
			dl_s[st] <= dl_s[st-1];
		end
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [37:0] cmp;
		assign cmp = 38'(dl_s[ST_NUM+k]) << (DIV_N - 1 - k);
		for (genvar c = 0; c < 3; c++) begin : g_lane
			always_ff @(posedge clk) begin
				if ({1'b0, drem_s[c][ST_NUM+k]} >= cmp) begin
					drem_s[c][ST_NUM+k+1] <= 37'({1'b0, drem_s[c][ST_NUM+k]} - cmp);
					quo_s[c][ST_NUM+k+1]  <= {quo_s[c][ST_NUM+k][13:0], 1'b1};
				end else begin
					drem_s[c][ST_NUM+k+1] <= drem_s[c][ST_NUM+k];
					quo_s[c][ST_NUM+k+1]  <= {quo_s[c][ST_NUM+k][13:0], 1'b0};
				end
			end
		end
	end

	// ---------------- rotation quaternion
	logic signed [15:0] u_c  [3];
	logic signed [31:0] su_c [3];
	logic signed [15:0] r_s43 [4];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			u_c[c]  = ax_s[ST_QUO][c][15] ? -$signed({1'b0, quo_s[c][ST_QUO]})
			                              :  $signed({1'b0, quo_s[c][ST_QUO]});
			su_c[c] = sn_s[ST_QUO] * u_c[c] + 32'sd8192;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			r_s43[c] <= 16'(su_c[c] >>> 14);
		end
		r_s43[3] <= cs_s[ST_QUO];
	end

	// ---------------- Hamilton product r * q
	logic signed [15:0] qx, qy, qz, qw, rx, ry, rz, rw;
	logic signed [31:0] p_s44 [4][4];

	assign qx = qv_s[ST_R][0];
	assign qy = qv_s[ST_R][1];
	assign qz = qv_s[ST_R][2];
	assign qw = qv_s[ST_R][3];
	assign rx = r_s43[0];
	assign ry = r_s43[1];
	assign rz = r_s43[2];
	assign rw = r_s43[3];

	// terms stored with their sign, so each output is a plain four-way sum
	always_ff @(posedge clk) begin
		p_s44[0][0] <= rw * qx;  p_s44[0][1] <= rx * qw;
		p_s44[0][2] <= ry * qz;  p_s44[0][3] <= -(rz * qy);
		p_s44[1][0] <= rw * qy;  p_s44[1][1] <= -(rx * qz);
		p_s44[1][2] <= ry * qw;  p_s44[1][3] <= rz * qx;
		p_s44[2][0] <= rw * qz;  p_s44[2][1] <= rx * qy;
		p_s44[2][2] <= -(ry * qx); p_s44[2][3] <= rz * qw;
		p_s44[3][0] <= rw * qw;  p_s44[3][1] <= -(rx * qx);
		p_s44[3][2] <= -(ry * qy); p_s44[3][3] <= -(rz * qz);
	end

	logic signed [33:0] acc_c [4];
	logic signed [15:0] o_s45 [4];
	logic               ok_s45;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			acc_c[c] = 34'(p_s44[c][0]) + 34'(p_s44[c][1]) + 34'(p_s44[c][2])
			         + 34'(p_s44[c][3]) + 34'sd8192;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			o_s45[c] <= ok_s[ST_P] ? sat16(20'(acc_c[c] >>> 14)) : 16'sd0;
		end
		ok_s45 <= ok_s[ST_P];
	end

	assign done  = v_s[ST_OUT];
	assign out_x = o_s45[0];
	assign out_y = o_s45[1];
	assign out_z = o_s45[2];
	assign out_w = o_s45[3];
	assign ok    = ok_s45;

	// ---------------- checks
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done without a beat taken at the expected latency");

	a_zero_axis_out: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0
			&& out_w == 16'sd0)
		else $error("zero-axis result is not all zero");

	a_ok_tracks_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ok == ($past(axis_x, LATENCY) != 16'sd0 || $past(axis_y, LATENCY) != 16'sd0
			|| $past(axis_z, LATENCY) != 16'sd0))
		else $error("ok does not match the axis of its beat");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ST_NUM] && ok_s[ST_NUM] |-> dl_s[ST_NUM] != '0)
		else $error("axis length is zero for a nonzero axis");

endmodule

/* bench/tb_quaternion_axis_angle_rotate_unit.sv */
// ---------------------------------------------------------------------------
// tb_quaternion_axis_angle_rotate_unit
// Drives axis-angle rotation beats into the unit, from a directed table and then at
// random, and checks every result against a bit-exact predictor or a stored expectation.
// ---------------------------------------------------------------------------
module tb_quaternion_axis_angle_rotate_unit
	import qaar_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] qx, qy, qz, qw, ax, ay, az, ang;
	} rot_beat_t;

	typedef struct {
		logic signed [15:0] x, y, z, w;
		logic               ok;
	} rot_res_t;

	typedef struct {
		rot_beat_t b;
		logic      has_exp;
		rot_res_t  e;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
	logic done, ok;
	logic signed [15:0] out_x, out_y, out_z, out_w;

	rot_res_t rotated_q[$];
	int       mismatches = 0;
	longint   cycles = 0;

	always #5 clk = ~clk;

	quaternion_axis_angle_rotate_unit dut (.*);

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint rnd(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r = 0, bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint unit_part(longint a, longint len);
		longint m = a < 0 ? -a : a;
		longint q = ((m <<< 21) + (len >>> 1)) / len;
		if (q > 16384) q = 16384;
		return a < 0 ? -q : q;
	endfunction

	function automatic rot_res_t rotate_quat(rot_beat_t b);
		rot_res_t r;
		longint ax = b.ax, ay = b.ay, az = b.az;
		longint h, x, y, dx, dy, s, c, len, rx, ry, rz, rw;
		longint qx = b.qx, qy = b.qy, qz = b.qz, qw = b.qw;
		bit neg = 0;
		r = '{0, 0, 0, 0, 1'b0};
		if (ax == 0 && ay == 0 && az == 0) return r;
		len = int_sqrt(longint'(ax*ax + ay*ay + az*az) <<< 14);
		h = longint'(b.ang) * 131072;
		if (h > HALF_PI_Q30) begin
			h -= PI_Q30; neg = 1;
		end else if (h < -longint'(HALF_PI_Q30)) begin
			h += PI_Q30; neg = 1;
		end
		x = CORDIC_GAIN; y = 0;
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = fshr(y, i); dy = fshr(x, i);
			if (h >= 0) begin
				x -= dx; y += dy; h -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; h += ATAN_TAB[i];
			end
		end
		if (neg) begin
			x = -x; y = -y;
		end
		c = clampl(rnd(x, 16), -16384, 16384);
		s = clampl(rnd(y, 16), -16384, 16384);
		rx = rnd(s * unit_part(ax, len), 14);
		ry = rnd(s * unit_part(ay, len), 14);
		rz = rnd(s * unit_part(az, len), 14);
		rw = c;
		r.x = 16'(clampl(rnd(rw*qx + rx*qw + ry*qz - rz*qy, 14), -32768, 32767));
		r.y = 16'(clampl(rnd(rw*qy - rx*qz + ry*qw + rz*qx, 14), -32768, 32767));
		r.z = 16'(clampl(rnd(rw*qz + rx*qy - ry*qx + rz*qw, 14), -32768, 32767));
		r.w = 16'(clampl(rnd(rw*qw - rx*qx - ry*qy - rz*qz, 14), -32768, 32767));
		r.ok = 1'b1;
		return r;
	endfunction

	// one beat: random gap with start low, then hold start until taken
	task automatic send_beat(rot_beat_t b, bit has_exp, rot_res_t e);
		int gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		in_x <= b.qx; in_y <= b.qy; in_z <= b.qz; in_w <= b.qw;
		axis_x <= b.ax; axis_y <= b.ay; axis_z <= b.az; angle <= b.ang;
		do @(posedge clk); while (busy);
		rotated_q.push_back(has_exp ? e : rotate_quat(b));
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rfield();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(16384);
			3: return 16'($urandom_range(0, 64)) - 16'sd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic rot_beat_t rand_beat();
		rot_beat_t b;
		b.qx = rfield(); b.qy = rfield(); b.qz = rfield(); b.qw = rfield();
		b.ax = rfield(); b.ay = rfield(); b.az = rfield(); b.ang = rfield();
		if ($urandom_range(0, 19) == 0) begin
			b.ax = 0; b.ay = 0; b.az = 0;
		end
		return b;
	endfunction

	// results checked at the edge that ends the strobe cycle
	always @(posedge clk) begin
		rot_res_t e;
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				e = rotated_q.pop_front();
				if (e.x !== out_x || e.y !== out_y || e.z !== out_z || e.w !== out_w
						|| e.ok !== ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d ok%0b got %0d %0d %0d %0d ok%0b",
							e.x, e.y, e.z, e.w, e.ok, out_x, out_y, out_z, out_w, ok);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		rot_res_t zero_res = '{0, 0, 0, 0, 1'b0};
		rot_res_t none = '{0, 0, 0, 0, 1'b0};
		rot_beat_t b;
		// zero axis with extreme content
		rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0, 0, 0, 16'sh7fff},
			1'b1, zero_res});
		rows.push_back('{'{-1, -1, -1, -1, 0, 0, 0, 16'sh8000}, 1'b1, zero_res});
		// identity quaternion, various axes and angles
		rows.push_back('{'{0, 0, 0, 16384, 16384, 0, 0, 0}, 1'b0, none});
		rows.push_back('{'{0, 0, 0, 16384, 0, 16384, 0, 6434}, 1'b0, none});
		rows.push_back('{'{0, 0, 0, 16384, 0, 0, 16384, 12868}, 1'b0, none});
		rows.push_back('{'{0, 0, 0, 16384, 0, 0, -16384, -12868}, 1'b0, none});
		rows.push_back('{'{0, 0, 0, 16384, 1, 0, 0, 6434}, 1'b0, none});
		rows.push_back('{'{0, 0, 0, 16384, 0, 0, -1, 6435}, 1'b0, none});
		// angle extremes and pi wrap edges
		rows.push_back('{'{100, 200, 300, 400, 1000, 2000, 3000, 16'sh7fff}, 1'b0, none});
		rows.push_back('{'{100, 200, 300, 400, 1000, 2000, 3000, 16'sh8000}, 1'b0, none});
		rows.push_back('{'{100, 200, 300, 400, 1000, -2000, 3000, 12867}, 1'b0, none});
		rows.push_back('{'{100, 200, 300, 400, 1000, -2000, 3000, 12868}, 1'b0, none});
		rows.push_back('{'{100, 200, 300, 400, -1000, 2000, 3000, -12868}, 1'b0, none});
		rows.push_back('{'{100, 200, 300, 400, -1000, 2000, 3000, -12869}, 1'b0, none});
		// full-range axis and saturating product
		rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000, 3217}, 1'b0, none});
		rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 3217}, 1'b0, none});
		rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 1, -3217}, 1'b0, none});
		rows.push_back('{'{-1, -1, -1, -1, -1, -1, -1, -1}, 1'b0, none});

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) send_beat(rows[i].b, rows[i].has_exp, rows[i].e);
		for (int n = 0; n < 1050; n++) begin
			// drain the pipeline now and then
			if (n % 300 == 150) begin
				start <= 1'b0;
				while (rotated_q.size() != 0) @(negedge clk);
			end
			b = rand_beat();
			send_beat(b, 1'b0, none);
		end
		start <= 1'b0;
		while (rotated_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
